>>> rtl/cau_pkg.sv
// Shared constants and types for the complex arithmetic unit.
// No dependencies; used by every other file of the block.
package cau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   // Control that travels with each word through the divider stages.
   typedef struct packed {
      logic [1:0] cmd;
      logic       dz;
      logic       neg_re;
      logic       neg_im;
      logic       big_re;
      logic       big_im;
   } ctl_type;

endpackage

>>> rtl/cau_div_step.sv
// One registered restoring-division step for both result parts.
// Depends on cau_pkg for the command codes and the control struct.
module cau_div_step #(
   parameter int W     = cau_pkg::DATA_WIDTH,
   parameter int RW    = 3 * cau_pkg::DATA_WIDTH,
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              valid_i,
   input  cau_pkg::ctl_type  ctl_i,
   input  logic [2*W-1:0]    den_i,
   input  logic [RW-1:0]     rem_re_i,
   input  logic [RW-1:0]     rem_im_i,
   input  logic [W-1:0]      q_re_i,
   input  logic [W-1:0]      q_im_i,
   output logic              valid_o,
   output cau_pkg::ctl_type  ctl_o,
   output logic [2*W-1:0]    den_o,
   output logic [RW-1:0]     rem_re_o,
   output logic [RW-1:0]     rem_im_o,
   output logic [W-1:0]      q_re_o,
   output logic [W-1:0]      q_im_o
);

   logic              valid_ff;
   cau_pkg::ctl_type  ctl_ff;
   logic [2*W-1:0]    den_ff;
   logic [RW-1:0]     rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [W-1:0]      q_re_ff, q_im_ff, q_re_in, q_im_in;
   logic [RW-1:0]     dsh;
   logic              is_div, take_re, take_im;

   always_comb begin
      dsh       = RW'(den_i) << SHIFT;
      is_div    = (ctl_i.cmd == cau_pkg::CMD_DIV);
      take_re   = is_div && (rem_re_i >= dsh);
      take_im   = is_div && (rem_im_i >= dsh);
      rem_re_in = take_re ? (rem_re_i - dsh) : rem_re_i;
      rem_im_in = take_im ? (rem_im_i - dsh) : rem_im_i;
      // Other commands carry their finished magnitude through unchanged.
      q_re_in   = is_div ? {q_re_i[W-2:0], take_re} : q_re_i;
      q_im_in   = is_div ? {q_im_i[W-2:0], take_im} : q_im_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctl_ff    <= ctl_i;
         den_ff    <= den_i;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         q_re_ff   <= q_re_in;
         q_im_ff   <= q_im_in;
      end
   end

   assign valid_o  = valid_ff;
   assign ctl_o    = ctl_ff;
   assign den_o    = den_ff;
   assign rem_re_o = rem_re_ff;
   assign rem_im_o = rem_im_ff;
   assign q_re_o   = q_re_ff;
   assign q_im_o   = q_im_ff;

endmodule

>>> rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: add, subtract, multiply, divide.
// Depends on cau_pkg and instantiates cau_div_step.
//
// Usage: a request word carries two complex operands in signed fixed point
// (DATA_WIDTH bits, FRAC_BITS fractional) and a command in req_tuser. Every
// request produces exactly one response word with the result parts in
// rsp_tdata and the overflow and divide-by-zero flags in rsp_tuser.
// The block is a pipeline of DATA_WIDTH + 5 register stages: input, products,
// sums, sign-magnitude and range check, one stage per quotient bit of the
// restoring divider, and the saturating output register. Every command
// walks the same path, so results leave in request order. One word is
// accepted per cycle while the receiver takes responses; the rate is set by
// the single shared pipeline advance.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated. A synchronous reset
// clears all valid bits; data registers are not reset.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_re, a_im, b_re, b_im from the lowest bit up
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]   req_tdata,
   // command
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // res_re, res_im from the lowest bit up
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   // overflow, div_by_zero from the lowest bit up
   output logic [1:0]                          rsp_tuser
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int OUT_W = ((2*W+7)/8)*8;
   // Remainder must hold the shifted numerator and the divisor moved up by W.
   localparam int RW = (F + 1 > W) ? (2*W + F + 1) : (3*W);

   // The pipeline advances whenever the output register is free or drained.
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: capture the operands.
   logic                v1_ff;
   logic [1:0]          cmd1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= req_tuser;
         ar1_ff  <= req_tdata[W-1:0];
         ai1_ff  <= req_tdata[2*W-1:W];
         br1_ff  <= req_tdata[3*W-1:2*W];
         bi1_ff  <= req_tdata[4*W-1:3*W];
      end
   end

   // Stage 2: all partial products and the add or subtract result.
   logic                  v2_ff;
   logic [1:0]            cmd2_ff;
   logic signed [2*W-1:0] prr_ff, pii_ff, pir_ff, pri_ff, sqr_ff, sqi_ff;
   logic signed [W:0]     sre_ff, sim_ff, sre_in, sim_in;

   always_comb begin
      if (cmd1_ff == cau_pkg::CMD_SUB) begin
         sre_in = {ar1_ff[W-1], ar1_ff} - {br1_ff[W-1], br1_ff};
         sim_in = {ai1_ff[W-1], ai1_ff} - {bi1_ff[W-1], bi1_ff};
      end else begin
         sre_in = {ar1_ff[W-1], ar1_ff} + {br1_ff[W-1], br1_ff};
         sim_in = {ai1_ff[W-1], ai1_ff} + {bi1_ff[W-1], bi1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd2_ff <= cmd1_ff;
         prr_ff  <= ar1_ff * br1_ff;
         pii_ff  <= ai1_ff * bi1_ff;
         pir_ff  <= ai1_ff * br1_ff;
         pri_ff  <= ar1_ff * bi1_ff;
         sqr_ff  <= br1_ff * br1_ff;
         sqi_ff  <= bi1_ff * bi1_ff;
         sre_ff  <= sre_in;
         sim_ff  <= sim_in;
      end
   end

   // Stage 3: exact real and imaginary sums and the divisor.
   logic                v3_ff;
   logic [1:0]          cmd3_ff;
   logic signed [2*W:0] xre_ff, xim_ff, xre_in, xim_in;
   logic [2*W-1:0]      den3_ff;

   always_comb begin
      case (cmd2_ff)
         cau_pkg::CMD_MUL: begin
            xre_in = {prr_ff[2*W-1], prr_ff} - {pii_ff[2*W-1], pii_ff};
            xim_in = {pir_ff[2*W-1], pir_ff} + {pri_ff[2*W-1], pri_ff};
         end
         cau_pkg::CMD_DIV: begin
            xre_in = {prr_ff[2*W-1], prr_ff} + {pii_ff[2*W-1], pii_ff};
            xim_in = {pir_ff[2*W-1], pir_ff} - {pri_ff[2*W-1], pri_ff};
         end
         default: begin
            xre_in = {{W{sre_ff[W]}}, sre_ff};
            xim_in = {{W{sim_ff[W]}}, sim_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd3_ff <= cmd2_ff;
         xre_ff  <= xre_in;
         xim_ff  <= xim_in;
         den3_ff <= $unsigned(sqr_ff) + $unsigned(sqi_ff);
      end
   end

   // Stage 4: sign and magnitude, rescaling, and the quotient range check.
   logic             v4_ff;
   cau_pkg::ctl_type ctl4_ff, ctl4_in;
   logic [2*W-1:0]   den4_ff;
   logic [RW-1:0]    rre4_ff, rim4_ff, rre4_in, rim4_in;
   logic [W-1:0]     qre4_ff, qim4_ff, qre4_in, qim4_in;
   logic [2*W:0]     are, aim, mre, mim;
   logic [RW-1:0]    dtop;

   always_comb begin
      are  = xre_ff[2*W] ? $unsigned(-xre_ff) : $unsigned(xre_ff);
      aim  = xim_ff[2*W] ? $unsigned(-xim_ff) : $unsigned(xim_ff);
      // Products drop the fraction from the magnitude, which truncates toward zero.
      mre  = (cmd3_ff == cau_pkg::CMD_MUL) ? (are >> F) : are;
      mim  = (cmd3_ff == cau_pkg::CMD_MUL) ? (aim >> F) : aim;
      rre4_in = RW'(are) << F;
      rim4_in = RW'(aim) << F;
      dtop    = RW'(den3_ff) << W;
      ctl4_in.cmd    = cmd3_ff;
      ctl4_in.dz     = (cmd3_ff == cau_pkg::CMD_DIV) && (den3_ff == '0);
      ctl4_in.neg_re = xre_ff[2*W];
      ctl4_in.neg_im = xim_ff[2*W];
      if (cmd3_ff == cau_pkg::CMD_DIV) begin
         // A quotient of W bits or more saturates whatever its low bits are.
         ctl4_in.big_re = (rre4_in >= dtop);
         ctl4_in.big_im = (rim4_in >= dtop);
         qre4_in = '0;
         qim4_in = '0;
      end else begin
         ctl4_in.big_re = (mre[2*W:W] != '0);
         ctl4_in.big_im = (mim[2*W:W] != '0);
         qre4_in = mre[W-1:0];
         qim4_in = mim[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl4_ff <= ctl4_in;
         den4_ff <= den3_ff;
         rre4_ff <= rre4_in;
         rim4_ff <= rim4_in;
         qre4_ff <= qre4_in;
         qim4_ff <= qim4_in;
      end
   end

   // Divider: one quotient bit per stage, most significant first.
   logic             dv   [0:W];
   cau_pkg::ctl_type dctl [0:W];
   logic [2*W-1:0]   dden [0:W];
   logic [RW-1:0]    drre [0:W];
   logic [RW-1:0]    drim [0:W];
   logic [W-1:0]     dqre [0:W];
   logic [W-1:0]     dqim [0:W];

   assign dv[0]   = v4_ff;
   assign dctl[0] = ctl4_ff;
   assign dden[0] = den4_ff;
   assign drre[0] = rre4_ff;
   assign drim[0] = rim4_ff;
   assign dqre[0] = qre4_ff;
   assign dqim[0] = qim4_ff;

   for (genvar i = 0; i < W; i++) begin : g_div
      cau_div_step #(
         .W     (W),
         .RW    (RW),
         .SHIFT (W - 1 - i)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .valid_i  (dv[i]),
         .ctl_i    (dctl[i]),
         .den_i    (dden[i]),
         .rem_re_i (drre[i]),
         .rem_im_i (drim[i]),
         .q_re_i   (dqre[i]),
         .q_im_i   (dqim[i]),
         .valid_o  (dv[i+1]),
         .ctl_o    (dctl[i+1]),
         .den_o    (dden[i+1]),
         .rem_re_o (drre[i+1]),
         .rem_im_o (drim[i+1]),
         .q_re_o   (dqre[i+1]),
         .q_im_o   (dqim[i+1])
      );
   end

   // Output stage: saturate each part to the signed range and set the flags.
   cau_pkg::ctl_type cf;
   logic [W-1:0]     res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic             ovf_ff, dz_ff, ovf_in;
   logic             sat_re, sat_im;
   logic [W-1:0]     qre, qim;
   logic [W-1:0]     max_pos, min_neg;

   always_comb begin
      cf      = dctl[W];
      qre     = dqre[W];
      qim     = dqim[W];
      max_pos = {1'b0, {(W-1){1'b1}}};
      min_neg = {1'b1, {(W-1){1'b0}}};
      // A negative part may reach exactly the most negative value.
      sat_re = cf.big_re || (cf.neg_re ? (qre[W-1] && (qre[W-2:0] != '0)) : qre[W-1]);
      sat_im = cf.big_im || (cf.neg_im ? (qim[W-1] && (qim[W-2:0] != '0)) : qim[W-1]);
      if (cf.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         ovf_in    = 1'b0;
      end else begin
         res_re_in = sat_re ? (cf.neg_re ? min_neg : max_pos) : (cf.neg_re ? -qre : qre);
         res_im_in = sat_im ? (cf.neg_im ? min_neg : max_pos) : (cf.neg_im ? -qim : qim);
         ovf_in    = sat_re || sat_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ovf_ff    <= ovf_in;
         dz_ff     <= cf.dz;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({res_im_ff, res_re_ff});
   assign rsp_tuser  = {dz_ff, ovf_ff};

endmodule

>>> rtl/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to its top level.
// Depends on cau_pkg for the default width.
module cau_port_checks #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((4*DATA_WIDTH+7)/8)*8-1:0]   req_tdata,
   input logic [1:0]                          req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*DATA_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   input logic [1:0]                          rsp_tuser
);

   // The input side only waits while a response word is held back.
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow the output stall");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   // A zero divisor gives zero parts and never reports overflow.
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && (rsp_tdata == '0))
      else $error("divide by zero response not clean");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind complex_arithmetic_unit cau_port_checks #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
